@@ rtl/asdu_pkg.sv @@
// asdu_pkg: shared widths, constants and types of the averaged speed deadband update block
// no dependencies; imported by every module of the block

package asdu_pkg;

  // field widths
  localparam int MV_W   = 12;
  localparam int RATE_W = 22;

  // largest sample value
  localparam int unsigned MV_MAX = 4095;

  // full-scale input that maps onto max_driver_freq
  localparam int unsigned FULL_SCALE = 3073;
  localparam int FS_W = 12;

  // half width of the deadband around the stored rate
  localparam int unsigned BAND_HALF = 4;

  // max_driver_freq split as hi * FULL_SCALE + lo
  localparam int HI_Q_W = 11;
  localparam int HI_W   = 23;
  localparam int LO_W   = 2 * FS_W;

  // reciprocal for the hi quotient of a 22-bit rate by FULL_SCALE
  localparam int H_SHIFT   = RATE_W + FS_W;
  localparam int H_RECIP_W = 23;
  localparam logic [H_RECIP_W-1:0] H_RECIP =
    H_RECIP_W'(((64'd1 << H_SHIFT) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE));

  // reciprocal for the quotient of a 24-bit lo product by FULL_SCALE
  localparam int L_SHIFT   = LO_W + FS_W;
  localparam int L_RECIP_W = 25;
  localparam logic [L_RECIP_W-1:0] L_RECIP =
    L_RECIP_W'(((64'd1 << L_SHIFT) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE));

  // reset value of max_driver_freq and its split
  localparam int unsigned RESET_MAX_INT = 10000;
  localparam logic [RATE_W-1:0] RESET_MAX = RATE_W'(RESET_MAX_INT);
  localparam logic [HI_Q_W-1:0] RESET_H   = HI_Q_W'(RESET_MAX_INT / FULL_SCALE);
  localparam logic [FS_W-1:0]   RESET_L   = FS_W'(RESET_MAX_INT % FULL_SCALE);

  // what travels down the pipeline: a sample request or a reference rescale
  typedef enum logic {
    KIND_ITEM,
    KIND_REF
  } kind_t;

  // window stage to scaling stages
  typedef struct packed {
    logic            valid;
    kind_t           kind;
    logic [MV_W-1:0] mean;
  } stage_t;

  // scaling stages to the deadband compare
  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [MV_W-1:0]   mean;
    logic [RATE_W-1:0] rate;
  } res_t;

  // config sequencer status
  typedef struct packed {
    logic busy;
    logic inject;
  } cfg_ctl_t;

endpackage

@@ rtl/asdu_cfg.sv @@
// asdu_cfg: max_driver_freq register and its split into hi/lo parts after a write
// depends on asdu_pkg; drives the reference rescale request into the window stage

module asdu_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [asdu_pkg::RATE_W-1:0] cfg_wdata,
  input  logic                       ref_done,
  output logic [asdu_pkg::RATE_W-1:0] max_freq,
  output logic [asdu_pkg::HI_Q_W-1:0] freq_hi,
  output logic [asdu_pkg::FS_W-1:0]   freq_lo,
  output asdu_pkg::cfg_ctl_t          ctl
);
  import asdu_pkg::*;

  typedef enum logic [2:0] {
    CFG_IDLE,
    CFG_DIV,
    CFG_REM,
    CFG_INJECT,
    CFG_WAIT
  } cfg_state_t;

  cfg_state_t          state_r;
  logic                busy_r;
  logic                inject_r;
  logic [RATE_W-1:0]   max_r;
  logic [HI_Q_W-1:0]   h_r;
  logic [FS_W-1:0]     l_r;

  logic [RATE_W+H_RECIP_W-1:0] h_prod;
  logic [HI_Q_W-1:0]           h_nxt;
  logic [RATE_W-1:0]           h_times_fs;
  logic [RATE_W-1:0]           rem_full;
  logic [FS_W-1:0]             l_nxt;

  // hi = max / full scale by reciprocal, lo = max - hi * full scale
  always_comb begin
    h_prod     = (RATE_W+H_RECIP_W)'(max_r) * (RATE_W+H_RECIP_W)'(H_RECIP);
    h_nxt      = h_prod[H_SHIFT +: HI_Q_W];
    h_times_fs = RATE_W'(h_r) * RATE_W'(FULL_SCALE);
    rem_full   = max_r - h_times_fs;
    l_nxt      = rem_full[FS_W-1:0];
  end

  // sequencer: split the new value, then rescale the stored mean
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= CFG_IDLE;
      busy_r   <= 1'b0;
      inject_r <= 1'b0;
      max_r    <= RESET_MAX;
      h_r      <= RESET_H;
      l_r      <= RESET_L;
    end else begin
      inject_r <= (state_r == CFG_REM);
      if (cfg_we) begin
        max_r   <= cfg_wdata;
        busy_r  <= 1'b1;
        state_r <= CFG_DIV;
      end else begin
        unique case (state_r)
          CFG_IDLE: begin
            state_r <= CFG_IDLE;
          end
          CFG_DIV: begin
            h_r     <= h_nxt;
            state_r <= CFG_REM;
          end
          CFG_REM: begin
            l_r     <= l_nxt;
            state_r <= CFG_INJECT;
          end
          CFG_INJECT: begin
            state_r <= CFG_WAIT;
          end
          CFG_WAIT: begin
            if (ref_done) begin
              busy_r  <= 1'b0;
              state_r <= CFG_IDLE;
            end
          end
          default: begin
            state_r <= CFG_IDLE;
          end
        endcase
      end
    end
  end

  assign max_freq   = max_r;
  assign freq_hi    = h_r;
  assign freq_lo    = l_r;
  assign ctl.busy   = busy_r;
  assign ctl.inject = inject_r;

endmodule

@@ rtl/asdu_window.sv @@
// asdu_window: sample shift line, running window sum and truncated mean stage
// depends on asdu_pkg; feeds asdu_scale

module asdu_window #(
  parameter int WINDOW_LEN = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic [asdu_pkg::MV_W-1:0] sample,
  input  logic                     inject,
  input  logic [asdu_pkg::MV_W-1:0] ref_mean,
  input  logic                     take,
  output logic                     can_accept,
  output asdu_pkg::stage_t         stage_out
);
  import asdu_pkg::*;

  localparam int SUM_W   = $clog2(WINDOW_LEN * MV_MAX + 1);
  localparam int SHIFT_N = SUM_W + $clog2(WINDOW_LEN);
  localparam int RECIP_W = SHIFT_N + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_N =
    RECIP_W'(((64'd1 << SHIFT_N) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

  logic [MV_W-1:0]  ring_r [WINDOW_LEN];
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;
  logic             v1_r;
  stage_t           st2_r;

  logic              ld1;
  logic              ld2;
  logic [PROD_W-1:0] mean_prod;
  logic [MV_W-1:0]   mean_calc;

  // stage loads, sum update and exact mean by reciprocal
  always_comb begin
    ld2       = !st2_r.valid || take;
    ld1       = !v1_r || ld2;
    sum_nxt   = sum_r - SUM_W'(ring_r[WINDOW_LEN-1]) + SUM_W'(sample);
    mean_prod = PROD_W'(sum_r) * PROD_W'(RECIP_N);
    mean_calc = mean_prod[SHIFT_N +: MV_W];
  end

  // shift line and running sum, updated on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        ring_r[i] <= '0;
      end
      sum_r <= '0;
    end else if (accept) begin
      ring_r[0] <= sample;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        ring_r[i] <= ring_r[i-1];
      end
      sum_r <= sum_nxt;
    end
  end

  // sum stage valid and mean stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      st2_r.valid <= 1'b0;
      st2_r.kind  <= KIND_ITEM;
      st2_r.mean  <= '0;
    end else begin
      if (ld1) begin
        v1_r <= accept;
      end
      if (ld2) begin
        st2_r.valid <= v1_r || inject;
        if (v1_r) begin
          st2_r.kind <= KIND_ITEM;
          st2_r.mean <= mean_calc;
        end else begin
          st2_r.kind <= KIND_REF;
          st2_r.mean <= ref_mean;
        end
      end
    end
  end

  assign can_accept = ld1;
  assign stage_out  = st2_r;

endmodule

@@ rtl/asdu_scale.sv @@
// asdu_scale: three-stage linear map of a mean onto 0..max_driver_freq
// depends on asdu_pkg; fed by asdu_window, read by the top level compare

module asdu_scale (
  input  logic                        clk,
  input  logic                        rst_n,
  input  asdu_pkg::stage_t            stage_in,
  input  logic [asdu_pkg::HI_Q_W-1:0] freq_hi,
  input  logic [asdu_pkg::FS_W-1:0]   freq_lo,
  input  logic                        take,
  output logic                        ready,
  output asdu_pkg::res_t              res
);
  import asdu_pkg::*;

  localparam int T_W = LO_W + L_RECIP_W;

  logic            v3_r;
  kind_t           k3_r;
  logic [MV_W-1:0] m3_r;
  logic [HI_W-1:0] phi3_r;
  logic [LO_W-1:0] plo3_r;

  logic            v4_r;
  kind_t           k4_r;
  logic [MV_W-1:0] m4_r;
  logic [HI_W-1:0] phi4_r;
  logic [FS_W-1:0] t4_r;

  logic              v5_r;
  kind_t             k5_r;
  logic [MV_W-1:0]   m5_r;
  logic [RATE_W-1:0] rate5_r;

  logic            ld3;
  logic            ld4;
  logic            ld5;
  logic [MV_W-1:0] x_clip;
  logic [HI_W-1:0] phi_nxt;
  logic [LO_W-1:0] plo_nxt;
  logic [T_W-1:0]  t_prod;
  logic [HI_W-1:0] rate_sum;

  // x * max / fs = x * hi + (x * lo) / fs, with x clipped at full scale
  always_comb begin
    ld5      = !v5_r || take;
    ld4      = !v4_r || ld5;
    ld3      = !v3_r || ld4;
    x_clip   = (stage_in.mean > MV_W'(FULL_SCALE)) ? MV_W'(FULL_SCALE) : stage_in.mean;
    phi_nxt  = HI_W'(x_clip) * HI_W'(freq_hi);
    plo_nxt  = LO_W'(x_clip) * LO_W'(freq_lo);
    t_prod   = T_W'(plo3_r) * T_W'(L_RECIP);
    rate_sum = phi4_r + HI_W'(t4_r);
  end

  // product, quotient and sum stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (ld3) begin
        v3_r <= stage_in.valid;
      end
      if (ld4) begin
        v4_r <= v3_r;
      end
      if (ld5) begin
        v5_r <= v4_r;
      end
    end
  end

  // payload of the scaling stages
  always_ff @(posedge clk) begin
    if (ld3) begin
      k3_r   <= stage_in.kind;
      m3_r   <= stage_in.mean;
      phi3_r <= phi_nxt;
      plo3_r <= plo_nxt;
    end
    if (ld4) begin
      k4_r   <= k3_r;
      m4_r   <= m3_r;
      phi4_r <= phi3_r;
      t4_r   <= t_prod[L_SHIFT +: FS_W];
    end
    if (ld5) begin
      k5_r    <= k4_r;
      m5_r    <= m4_r;
      rate5_r <= rate_sum[RATE_W-1:0];
    end
  end

  assign ready     = ld3;
  assign res.valid = v5_r;
  assign res.kind  = k5_r;
  assign res.mean  = m5_r;
  assign res.rate  = rate5_r;

endmodule

@@ rtl/averaged_speed_deadband_update_top.sv @@
// averaged_speed_deadband_update_top: moving average of samples, scaled, sent past a deadband
// depends on asdu_pkg, asdu_cfg, asdu_window and asdu_scale
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_sample_mv
//   out_     output     out_valid/out_stall  out_new_rate, out_average_mv
//   cfg_     input      cfg_we               cfg_wdata (max_driver_freq)
//
// one request per cycle is taken while in_stall is low
// a request passes the sum, mean, product, quotient and sum stages ahead of the output register
// requests that stay inside the deadband give no result and leave a bubble
// after a config write in_stall is high while max_driver_freq is split and
// the stored mean is rescaled through the same scaling stages
// rst_n clears the window, the stored mean and all valid bits; max_driver_freq returns to 10000
// an unread result holds the output register; the stages ahead keep filling until full

module averaged_speed_deadband_update_top #(
  parameter int WINDOW_LEN = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [asdu_pkg::MV_W-1:0]   in_sample_mv,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [asdu_pkg::RATE_W-1:0] out_new_rate,
  output logic [asdu_pkg::MV_W-1:0]   out_average_mv,
  input  logic                        cfg_we,
  input  logic [asdu_pkg::RATE_W-1:0] cfg_wdata
);
  import asdu_pkg::*;

  cfg_ctl_t          ctl;
  logic [RATE_W-1:0] max_freq;
  logic [HI_Q_W-1:0] freq_hi;
  logic [FS_W-1:0]   freq_lo;
  logic              can_accept;
  logic              scale_ready;
  stage_t            win_stage;
  res_t              res;

  logic              accept;
  logic              out_en;
  logic              ref_done;
  logic              outside;
  logic              emit;
  logic [RATE_W-1:0] band_lo;
  logic [RATE_W:0]   band_hi_sum;
  logic [RATE_W-1:0] band_hi;

  logic              out_valid_r;
  logic [RATE_W-1:0] out_rate_r;
  logic [MV_W-1:0]   out_mean_r;
  logic [MV_W-1:0]   acc_mean_r;
  logic [RATE_W-1:0] ref_rate_r;

  // config register and rescale sequencer
  asdu_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ref_done  (ref_done),
    .max_freq  (max_freq),
    .freq_hi   (freq_hi),
    .freq_lo   (freq_lo),
    .ctl       (ctl)
  );

  // window sum and mean
  asdu_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .sample     (in_sample_mv),
    .inject     (ctl.inject),
    .ref_mean   (acc_mean_r),
    .take       (scale_ready),
    .can_accept (can_accept),
    .stage_out  (win_stage)
  );

  // linear map onto the rate range
  asdu_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .stage_in (win_stage),
    .freq_hi  (freq_hi),
    .freq_lo  (freq_lo),
    .take     (out_en),
    .ready    (scale_ready),
    .res      (res)
  );

  // handshake and deadband clipped at zero and at the maximum
  always_comb begin
    in_stall    = ctl.busy || !can_accept;
    accept      = in_valid && !in_stall;
    out_en      = !out_valid_r || !out_stall;
    ref_done    = res.valid && (res.kind == KIND_REF) && out_en;
    band_lo     = (ref_rate_r > RATE_W'(BAND_HALF)) ? ref_rate_r - RATE_W'(BAND_HALF) : '0;
    band_hi_sum = {1'b0, ref_rate_r} + (RATE_W+1)'(BAND_HALF);
    band_hi     = (band_hi_sum < {1'b0, max_freq}) ? band_hi_sum[RATE_W-1:0] : max_freq;
    outside     = (res.rate < band_lo) || (res.rate > band_hi);
    emit        = res.valid && (res.kind == KIND_ITEM) && outside;
  end

  // output register, stored mean and its scaled rate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      acc_mean_r  <= '0;
      ref_rate_r  <= '0;
    end else if (out_en) begin
      out_valid_r <= emit;
      if (emit) begin
        acc_mean_r <= res.mean;
        ref_rate_r <= res.rate;
      end else if (ref_done) begin
        ref_rate_r <= res.rate;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_en && emit) begin
      out_rate_r <= res.rate;
      out_mean_r <= res.mean;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_new_rate   = out_rate_r;
  assign out_average_mv = out_mean_r;

endmodule

@@ rtl/asdu_checker.sv @@
// asdu_checker: port-level assertions for averaged_speed_deadband_update_top
// depends on asdu_pkg; attached to the top level by the bind at the end of this file

module asdu_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [asdu_pkg::RATE_W-1:0] out_new_rate,
  input logic [asdu_pkg::MV_W-1:0]   out_average_mv,
  input logic                        cfg_we
);
  import asdu_pkg::*;

  // a stalled result stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_new_rate) && $stable(out_average_mv))
    else $error("stalled result request changed or dropped");

  // a config write holds off requests while the new value is split
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_stall ##1 in_stall)
    else $error("request taken during config rescale");

  // reset leaves the block ready and with no result pending
  a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_stall && !out_valid)
    else $error("pipeline not cleared by reset");

endmodule

bind averaged_speed_deadband_update_top asdu_checker u_asdu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_new_rate   (out_new_rate),
  .out_average_mv (out_average_mv),
  .cfg_we         (cfg_we)
);

@@ tb/tb_top.sv @@
// tb_top: self-checking bench for averaged_speed_deadband_update_top, windowed mean past a deadband
// depends on asdu_pkg and the averaged_speed_deadband_update_top rtl
// a directed table, then phased random requests under several max_driver_freq settings
`timescale 1ns / 100ps

module tb_top;
  import asdu_pkg::*;

  localparam int WIN = 8;
  localparam int NUM_ROWS = 28;
  localparam int NUM_PHASES = 9;
  localparam int PHASE_ITEMS = 170;
  localparam int DRAIN_CYCLES = 20;

  // directed table: a sample request or a max_driver_freq write
  typedef enum logic {
    ROW_SAMPLE,
    ROW_CFG
  } row_kind_t;

  // how the expected result of a row is obtained
  typedef enum logic [1:0] {
    EXP_PREDICT,
    EXP_NONE,
    EXP_HIT
  } row_exp_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [RATE_W-1:0] value;
    row_exp_t          exp_kind;
    logic [RATE_W-1:0] rate;
    logic [MV_W-1:0]   mean;
  } dir_row_t;

  // one rate update on the out channel
  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [MV_W-1:0]   mean;
  } rate_update_t;

  // shapes of the random sample stream
  typedef enum logic [1:0] {
    SHAPE_HOLD,
    SHAPE_RAMP,
    SHAPE_JUMP,
    SHAPE_NOISE
  } shape_t;

  localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
    '{ROW_SAMPLE, 0,       EXP_NONE,    0,    0},
    '{ROW_SAMPLE, 0,       EXP_NONE,    0,    0},
    '{ROW_SAMPLE, 4095,    EXP_HIT,     1662, 511},
    '{ROW_SAMPLE, 4095,    EXP_PREDICT, 0,    0},
    '{ROW_SAMPLE, 4095,    EXP_PREDICT, 0,    0},
    '{ROW_SAMPLE, 4095,    EXP_PREDICT, 0,    0},
    '{ROW_SAMPLE, 4095,    EXP_PREDICT, 0,    0},
    '{ROW_SAMPLE, 4095,    EXP_PREDICT, 0,    0},
    '{ROW_SAMPLE, 4095,    EXP_PREDICT, 0,    0},
    '{ROW_SAMPLE, 4095,    EXP_PREDICT, 0,    0},
    '{ROW_SAMPLE, 3073,    EXP_PREDICT, 0,    0},
    '{ROW_SAMPLE, 1,       EXP_PREDICT, 0,    0},
    '{ROW_SAMPLE, 2048,    EXP_PREDICT, 0,    0},
    '{ROW_CFG,    0,       EXP_NONE,    0,    0},
    '{ROW_SAMPLE, 4095,    EXP_NONE,    0,    0},
    '{ROW_SAMPLE, 0,       EXP_NONE,    0,    0},
    '{ROW_SAMPLE, 2730,    EXP_NONE,    0,    0},
    '{ROW_CFG,    3,       EXP_NONE,    0,    0},
    '{ROW_SAMPLE, 0,       EXP_PREDICT, 0,    0},
    '{ROW_SAMPLE, 4095,    EXP_PREDICT, 0,    0},
    '{ROW_CFG,    4194303, EXP_NONE,    0,    0},
    '{ROW_SAMPLE, 0,       EXP_PREDICT, 0,    0},
    '{ROW_SAMPLE, 4095,    EXP_PREDICT, 0,    0},
    '{ROW_SAMPLE, 2730,    EXP_PREDICT, 0,    0},
    '{ROW_SAMPLE, 1365,    EXP_PREDICT, 0,    0},
    '{ROW_CFG,    8,       EXP_NONE,    0,    0},
    '{ROW_SAMPLE, 3073,    EXP_PREDICT, 0,    0},
    '{ROW_SAMPLE, 0,       EXP_PREDICT, 0,    0}
  };

  // fixed settings for the first random phases, the rest draw one
  localparam int unsigned PHASE_FREQ [7] = '{8, 4000000, 4194303, 0, 1, 3073, 10000};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [MV_W-1:0]   in_sample_mv = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [RATE_W-1:0] out_new_rate;
  logic [MV_W-1:0]   out_average_mv;
  logic              cfg_we = 1'b0;
  logic [RATE_W-1:0] cfg_wdata = '0;

  // window and deadband state mirrored from the block
  logic [MV_W-1:0]   ring_mv [WIN];
  logic [14:0]       sum_mv;
  int unsigned       slot;
  logic [MV_W-1:0]   stored_mean;
  logic [RATE_W-1:0] freq_max;

  rate_update_t      pending_updates [$];
  int                errors = 0;

  // idling control: 0 means none, otherwise a burst starts at odds of one in N
  int                sender_odds = 0;
  int                stall_odds = 0;
  int                stall_left = 0;

  // random stream state
  shape_t            shape = SHAPE_HOLD;
  int                shape_left = 0;
  int                level = 0;
  int                ramp_step = 0;

  averaged_speed_deadband_update_top #(.WINDOW_LEN(WIN)) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_mv   (in_sample_mv),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_new_rate   (out_new_rate),
    .out_average_mv (out_average_mv),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always #1 clk = ~clk;

  // millivolts to rate, truncated and saturated at max_driver_freq
  function automatic logic [RATE_W-1:0] rate_of_mv(logic [MV_W-1:0] mv);
    longint unsigned q;
    q = (longint'(mv) * longint'(freq_max)) / longint'(FULL_SCALE);
    if (q > longint'(freq_max)) begin
      q = longint'(freq_max);
    end
    return RATE_W'(q);
  endfunction

  // push one sample through the window and decide if it leaves the deadband
  task automatic average_and_band(input logic [MV_W-1:0] sample, output bit hit,
                                  output rate_update_t upd);
    logic [MV_W-1:0]   mean;
    logic [RATE_W-1:0] ref_rate;
    logic [RATE_W-1:0] avg_rate;
    int unsigned       low;
    int unsigned       high;
    sum_mv = sum_mv - 15'(ring_mv[slot]) + 15'(sample);
    ring_mv[slot] = sample;
    slot = (slot + 1) % WIN;
    mean = MV_W'(sum_mv / WIN);
    ref_rate = rate_of_mv(stored_mean);
    avg_rate = rate_of_mv(mean);
    low = (ref_rate > BAND_HALF) ? ref_rate - BAND_HALF : 0;
    high = (ref_rate + BAND_HALF < freq_max) ? ref_rate + BAND_HALF : freq_max;
    hit = (avg_rate < low) || (avg_rate > high);
    upd.rate = avg_rate;
    upd.mean = mean;
    if (hit) begin
      stored_mean = mean;
    end
  endtask

  // drive one sample request, wait for it to be taken, then record what it should give
  task automatic send_sample(input logic [MV_W-1:0] sample, input row_exp_t exp_kind,
                             input rate_update_t typed);
    bit           hit;
    rate_update_t upd;
    if (sender_odds != 0 && $urandom_range(1, sender_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_mv <= sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    average_and_band(sample, hit, upd);
    case (exp_kind)
      EXP_HIT: pending_updates.push_back(typed);
      EXP_PREDICT: if (hit) pending_updates.push_back(upd);
      default: ;
    endcase
  endtask

  // write max_driver_freq once the block has drained
  task automatic write_max_freq(input logic [RATE_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    freq_max = value;
  endtask

  function automatic int pick_level();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 4095;
      2: return 3073 + int'($urandom_range(0, 1022));
      default: return int'($urandom_range(0, 4095));
    endcase
  endfunction

  // next random sample: mostly held levels, ramps and steps, some plain noise
  task automatic next_sample(output logic [MV_W-1:0] sample);
    int v;
    if (shape_left == 0) begin
      case ($urandom_range(0, 7))
        0: shape = SHAPE_NOISE;
        1, 2: shape = SHAPE_RAMP;
        3, 4: shape = SHAPE_JUMP;
        default: shape = SHAPE_HOLD;
      endcase
      shape_left = $urandom_range(4, 40);
      level = pick_level();
      ramp_step = int'($urandom_range(0, 400)) - 200;
    end
    shape_left--;
    case (shape)
      SHAPE_HOLD: v = level + int'($urandom_range(0, 6)) - 3;
      SHAPE_RAMP: begin
        level = level + ramp_step;
        if (level < 0) level = 0;
        if (level > 4095) level = 4095;
        v = level;
      end
      SHAPE_JUMP: begin
        v = level;
        if ($urandom_range(0, 9) == 0) level = pick_level();
      end
      default: v = int'($urandom_range(0, 4095));
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    sample = MV_W'(v);
  endtask

  // out side stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare every taken rate update with the oldest one expected
  always @(posedge clk) begin
    rate_update_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_updates.size() == 0) begin
        $error("unexpected out request: new_rate %0d average_mv %0d",
               out_new_rate, out_average_mv);
        errors++;
      end else begin
        want = pending_updates.pop_front();
        if (out_new_rate !== want.rate) begin
          $error("new_rate: expected %0d, actual %0d", want.rate, out_new_rate);
          errors++;
        end
        if (out_average_mv !== want.mean) begin
          $error("average_mv: expected %0d, actual %0d", want.mean, out_average_mv);
          errors++;
        end
      end
    end
  end

  // main sequence
  initial begin
    logic [MV_W-1:0]   sample;
    logic [RATE_W-1:0] freq;
    rate_update_t      typed;
    for (int i = 0; i < WIN; i++) ring_mv[i] = '0;
    sum_mv = '0;
    slot = 0;
    stored_mean = '0;
    freq_max = RESET_MAX;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    sender_odds = 4;
    stall_odds = 4;
    foreach (DIR_ROWS[r]) begin
      if (DIR_ROWS[r].kind == ROW_CFG) begin
        write_max_freq(DIR_ROWS[r].value);
      end else begin
        typed.rate = DIR_ROWS[r].rate;
        typed.mean = DIR_ROWS[r].mean;
        send_sample(MV_W'(DIR_ROWS[r].value), DIR_ROWS[r].exp_kind, typed);
      end
    end

    // random phases, each under its own max_driver_freq; the last one runs without idling
    typed = '0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      freq = (p < 7) ? RATE_W'(PHASE_FREQ[p]) : RATE_W'($urandom_range(8, 4000000));
      write_max_freq(freq);
      if (p == NUM_PHASES - 1) begin
        sender_odds = 0;
        stall_odds = 0;
      end else begin
        sender_odds = ($urandom_range(0, 3) == 0) ? 0 : 3 * int'($urandom_range(1, 4));
        stall_odds = ($urandom_range(0, 3) == 0) ? 0 : 3 * int'($urandom_range(1, 4));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        next_sample(sample);
        send_sample(sample, EXP_PREDICT, typed);
      end
    end

    // drain and report
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("averaged_speed_deadband_update_top: match");
    end else begin
      $display("averaged_speed_deadband_update_top: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #800000;
    $display("averaged_speed_deadband_update_top: mismatch");
    $finish;
  end

endmodule
